/* src/sli_pkg.sv */
`timescale 1ns / 1ps

package sli_pkg;

    // widths fixed by the item format
    localparam int KEY_W         = 32;
    localparam int OP_W          = 2;
    localparam int LIST_DEPTH_DF = 64;

    // opcodes of an input item
    localparam logic [OP_W-1:0] OP_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [KEY_W-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] match_value;
        logic                    match_valid;
        logic                    last_result;
    } t_out_item;

    // walker states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

/* src/sli_store.sv */
`timescale 1ns / 1ps

module sli_store
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DF
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] i_waddr,
    input  logic [KEY_W-1:0]                           i_wdata,
    input  logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] i_raddr,
    output logic [KEY_W-1:0]                           o_rdata
);

    logic [KEY_W-1:0] r_mem [0:LIST_DEPTH-1];
    logic [KEY_W-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/sli_ctrl.sv */
`timescale 1ns / 1ps

module sli_ctrl
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  t_in_item                                   i_in_item,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output t_out_item                                  o_out_item,
    output logic                                       o_we_l,
    output logic                                       o_we_r,
    output logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] o_waddr_l,
    output logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] o_waddr_r,
    output logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] o_raddr_l,
    output logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] o_raddr_r,
    input  logic [KEY_W-1:0]                           i_rdata_l,
    input  logic [KEY_W-1:0]                           i_rdata_r
);

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_lcnt, n_lcnt, r_rcnt, n_rcnt;
    logic [CNT_W-1:0]  r_li, n_li, r_ri, n_ri;
    logic [KEY_W-1:0]  r_pend, n_pend;
    logic              r_pend_vld, n_pend_vld;
    logic              r_out_vld, n_out_vld;
    t_out_item         r_out, n_out;

    logic              acc;
    logic              free;
    logic              push;
    t_out_item         push_item;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;
    assign free       = !r_out_vld || i_out_ready;

    // store access: append at the count, read at the walk pointers
    assign o_we_l    = acc && (i_in_item.opcode == OP_LEFT) && (r_lcnt < DEPTH_C);
    assign o_we_r    = acc && (i_in_item.opcode == OP_RIGHT) && (r_rcnt < DEPTH_C);
    assign o_waddr_l = r_lcnt[ADDR_W-1:0];
    assign o_waddr_r = r_rcnt[ADDR_W-1:0];
    assign o_raddr_l = r_li[ADDR_W-1:0];
    assign o_raddr_r = r_ri[ADDR_W-1:0];

    // walker
    always_comb begin
        n_state    = r_state;
        n_lcnt     = r_lcnt;
        n_rcnt     = r_rcnt;
        n_li       = r_li;
        n_ri       = r_ri;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        push       = 1'b0;
        push_item  = '{match_value: r_pend, match_valid: 1'b0, last_result: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (o_we_l) begin
                    n_lcnt = r_lcnt + 1'b1;
                end
                if (o_we_r) begin
                    n_rcnt = r_rcnt + 1'b1;
                end
                if (acc && (i_in_item.opcode == OP_RUN)) begin
                    n_li       = '0;
                    n_ri       = '0;
                    n_pend_vld = 1'b0;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if ((r_li < r_lcnt) && (r_ri < r_rcnt)) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (i_rdata_l == i_rdata_r) begin
                    if (r_pend_vld && (r_pend == i_rdata_l)) begin
                        // repeated key, already held
                        n_li    = r_li + 1'b1;
                        n_ri    = r_ri + 1'b1;
                        n_state = S_READ;
                    end else if (!r_pend_vld) begin
                        n_pend     = i_rdata_l;
                        n_pend_vld = 1'b1;
                        n_li       = r_li + 1'b1;
                        n_ri       = r_ri + 1'b1;
                        n_state    = S_READ;
                    end else if (free) begin
                        // new key: the held match is not the last one
                        push       = 1'b1;
                        push_item  = '{match_value: r_pend, match_valid: 1'b1,
                                       last_result: 1'b0};
                        n_pend     = i_rdata_l;
                        n_li       = r_li + 1'b1;
                        n_ri       = r_ri + 1'b1;
                        n_state    = S_READ;
                    end
                end else if ($signed(i_rdata_r) < $signed(i_rdata_l)) begin
                    n_ri    = r_ri + 1'b1;
                    n_state = S_READ;
                end else begin
                    n_li    = r_li + 1'b1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (free) begin
                    push = 1'b1;
                    if (r_pend_vld) begin
                        push_item = '{match_value: r_pend, match_valid: 1'b1,
                                      last_result: 1'b1};
                    end else begin
                        push_item = '{match_value: '0, match_valid: 1'b0,
                                      last_result: 1'b1};
                    end
                    n_lcnt     = '0;
                    n_rcnt     = '0;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (push) begin
            n_out_vld = 1'b1;
            n_out     = push_item;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lcnt     <= '0;
            r_rcnt     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_lcnt     <= n_lcnt;
            r_rcnt     <= n_rcnt;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_li   <= n_li;
        r_ri   <= n_ri;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lcnt <= DEPTH_C) && (r_rcnt <= DEPTH_C))
        else $error("list count beyond depth");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!r_out_vld || i_out_ready))
        else $error("result pushed over an untaken result");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && free) |=> (r_lcnt == '0 && r_rcnt == '0 && r_state == S_IDLE))
        else $error("run end did not clear counts");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_li < r_lcnt) && (r_ri < r_rcnt)))
        else $error("compare outside list bounds");

endmodule

/* src/sorted_list_intersection.sv */
`timescale 1ns / 1ps
// load items (append left or right) are taken one per cycle, no result
// a run walks both stores, each merge step a read state then a compare state, and blocks the
// input until the walk ends and the last result is pushed, plus stalls on an untaken result
// a match is held until the next new match or the walk end, then goes to the output register
// synchronous active-low reset clears both counts, the walker state and the output valid;
// the key stores are not cleared and are only read below the counts

module sorted_list_intersection
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic              we_l, we_r;
    logic [ADDR_W-1:0] waddr_l, waddr_r, raddr_l, raddr_r;
    logic [KEY_W-1:0]  rdata_l, rdata_r;

    // merge controller with counts and output register
    sli_ctrl #(.LIST_DEPTH(LIST_DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_we_l      (we_l),
        .o_we_r      (we_r),
        .o_waddr_l   (waddr_l),
        .o_waddr_r   (waddr_r),
        .o_raddr_l   (raddr_l),
        .o_raddr_r   (raddr_r),
        .i_rdata_l   (rdata_l),
        .i_rdata_r   (rdata_r)
    );

    // left key store
    sli_store #(.LIST_DEPTH(LIST_DEPTH)) u_left (
        .i_clk   (i_clk),
        .i_we    (we_l),
        .i_waddr (waddr_l),
        .i_wdata (i_in_item.key_value),
        .i_raddr (raddr_l),
        .o_rdata (rdata_l)
    );

    // right key store
    sli_store #(.LIST_DEPTH(LIST_DEPTH)) u_right (
        .i_clk   (i_clk),
        .i_we    (we_r),
        .i_waddr (waddr_r),
        .i_wdata (i_in_item.key_value),
        .i_raddr (raddr_r),
        .o_rdata (rdata_r)
    );

endmodule

/* tb/tb_sorted_list_intersection.sv */
`timescale 1ns / 1ps

module tb_sorted_list_intersection;
    import sli_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 270;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 300;

    typedef struct {
        t_in_item item;
        bit       hold_for_drain;
    } t_planned_item;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      drv_valid = 1'b0;
    t_in_item  drv_item = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    logic      rx_ready = 1'b0;
    t_out_item o_out_item;

    // items waiting to be offered, and matches still owed by the block
    t_planned_item items_todo[$];
    t_out_item     owed_matches[$];

    // own copy of both key lists
    logic signed [KEY_W-1:0] left_keys [LIST_DEPTH_DF];
    logic signed [KEY_W-1:0] right_keys [LIST_DEPTH_DF];
    int left_len = 0;
    int right_len = 0;

    int  errors = 0;
    int  items_planned = 0;
    int  items_sent = 0;
    int  runs_sent = 0;
    int  loads_dropped = 0;
    int  results_seen = 0;
    int  cycles = 0;
    int  send_gap = 0;
    int  send_burst = 0;
    int  rx_stall = 0;
    int  rx_burst = 0;
    bit  long_hold_done = 1'b0;
    bit  drain_next = 1'b0;

    sorted_list_intersection #(
        .LIST_DEPTH(LIST_DEPTH_DF)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (drv_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (drv_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(rx_ready),
        .o_out_item (o_out_item)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    // idle length: mostly none, some short, a few long, with idle-free bursts
    function automatic int draw_idle(inout int burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if (r < 5) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // apply one accepted item to the key lists, queue the matches a run gives
    task automatic predict_intersection(input t_in_item it);
        int li;
        int ri;
        int n;
        logic signed [KEY_W-1:0] prev;
        t_out_item m;
        li = 0;
        ri = 0;
        n = 0;
        prev = '0;
        case (it.opcode)
            OP_LEFT: begin
                if (left_len < LIST_DEPTH_DF) begin
                    left_keys[left_len] = it.key_value;
                    left_len++;
                end else begin
                    loads_dropped++;
                end
            end
            OP_RIGHT: begin
                if (right_len < LIST_DEPTH_DF) begin
                    right_keys[right_len] = it.key_value;
                    right_len++;
                end else begin
                    loads_dropped++;
                end
            end
            OP_RUN: begin
                // two-pointer merge, repeated matches collapsed
                while (li < left_len && ri < right_len) begin
                    if (left_keys[li] == right_keys[ri]) begin
                        if (n == 0 || prev != left_keys[li]) begin
                            m.match_value = left_keys[li];
                            m.match_valid = 1'b1;
                            m.last_result = 1'b0;
                            owed_matches.insert(owed_matches.size(), m);
                            prev = left_keys[li];
                            n++;
                        end
                        li++;
                        ri++;
                    end else if (right_keys[ri] < left_keys[li]) begin
                        ri++;
                    end else begin
                        li++;
                    end
                end
                if (n == 0) begin
                    m.match_value = '0;
                    m.match_valid = 1'b0;
                    m.last_result = 1'b1;
                    owed_matches.insert(owed_matches.size(), m);
                end else begin
                    owed_matches[owed_matches.size() - 1].last_result = 1'b1;
                end
                left_len = 0;
                right_len = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic plan_item(input logic [OP_W-1:0] op, input int key);
        t_planned_item p;
        p.item.opcode = op;
        p.item.key_value = key;
        p.hold_for_drain = drain_next;
        drain_next = 1'b0;
        items_todo.insert(items_todo.size(), p);
        if (op != OP_UNUSED) items_planned++;
    endtask

    // one set: two lists from a shared start, loads interleaved, then a run
    task automatic plan_set(input int n_left, input int n_right, input int start,
                            input int unsigned max_step, input bit sorted);
        int     lq[$];
        int     rq[$];
        longint v;
        int     i;
        v = start;
        for (i = 0; i < n_left; i++) begin
            if (sorted) begin
                v += $urandom_range(0, max_step);
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                lq.insert(lq.size(), int'(v));
            end else begin
                lq.insert(lq.size(), start + int'($urandom_range(0, 15)));
            end
        end
        v = start;
        for (i = 0; i < n_right; i++) begin
            if (sorted) begin
                v += $urandom_range(0, max_step);
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                rq.insert(rq.size(), int'(v));
            end else begin
                rq.insert(rq.size(), start + int'($urandom_range(0, 15)));
            end
        end
        while (lq.size() != 0 || rq.size() != 0) begin
            if ($urandom_range(0, 99) < 3) plan_item(OP_UNUSED, int'($urandom));
            if (rq.size() == 0 || (lq.size() != 0 && $urandom_range(0, 1) == 1)) begin
                plan_item(OP_LEFT, lq.pop_front());
            end else begin
                plan_item(OP_RIGHT, rq.pop_front());
            end
        end
        plan_item(OP_RUN, int'($urandom));
    endtask

    // driver: offers queued items, predicts each one on acceptance
    always @(posedge i_clk) begin : drive_items
        logic     next_valid;
        t_in_item next_item;
        next_valid = drv_valid;
        next_item  = drv_item;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (drv_valid && o_in_ready) begin
                predict_intersection(drv_item);
                items_sent++;
                if (drv_item.opcode == OP_RUN) runs_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (items_todo.size() != 0 &&
                             !(items_todo[0].hold_for_drain && owed_matches.size() != 0)) begin
                    next_valid = 1'b1;
                    next_item  = items_todo[0].item;
                    items_todo.delete(0);
                    send_gap = draw_idle(send_burst);
                end
            end
        end
        drv_valid <= next_valid;
        drv_item  <= next_item;
    end

    // receiver ready, with one long hold-off once results are flowing
    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            rx_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 12) begin
            long_hold_done = 1'b1;
            rx_stall = 400;
            rx_ready <= 1'b0;
        end else begin
            rx_stall = draw_idle(rx_burst);
            rx_ready <= (rx_stall == 0);
        end
    end

    // monitor: compare each result with the oldest owed match
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && rx_ready) begin
            results_seen++;
            if (owed_matches.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value %0d valid %0b last %0b", $time,
                         o_out_item.match_value, o_out_item.match_valid,
                         o_out_item.last_result);
            end else begin
                want = owed_matches.pop_front();
                if (o_out_item.match_value !== want.match_value) begin
                    errors++;
                    $display("%0t: match_value expected %0d actual %0d", $time,
                             want.match_value, o_out_item.match_value);
                end
                if (o_out_item.match_valid !== want.match_valid) begin
                    errors++;
                    $display("%0t: match_valid expected %0b actual %0b", $time,
                             want.match_valid, o_out_item.match_valid);
                end
                if (o_out_item.last_result !== want.last_result) begin
                    errors++;
                    $display("%0t: last_result expected %0b actual %0b", $time,
                             want.last_result, o_out_item.last_result);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int r;
        int start;
        bit full_done;
        full_done = 1'b0;

        // run on empty lists, then with the right list empty
        plan_item(OP_RUN, 0);
        plan_item(OP_LEFT, 5);
        plan_item(OP_RUN, -1);
        // key extremes, duplicates on both sides, unused opcode
        plan_item(OP_UNUSED, -1);
        plan_item(OP_LEFT, 32'sh8000_0000);
        plan_item(OP_LEFT, 32'sh8000_0000);
        plan_item(OP_LEFT, 0);
        plan_item(OP_LEFT, 32'sh7fff_ffff);
        plan_item(OP_RIGHT, 32'sh8000_0000);
        plan_item(OP_RIGHT, 32'sh8000_0000);
        plan_item(OP_RIGHT, -1);
        plan_item(OP_RIGHT, 0);
        plan_item(OP_RIGHT, 32'sh7fff_ffff);
        plan_item(OP_UNUSED, 0);
        plan_item(OP_RUN, 0);
        // disjoint lists
        plan_item(OP_LEFT, 1);
        plan_item(OP_LEFT, 3);
        plan_item(OP_RIGHT, 2);
        plan_item(OP_RIGHT, 4);
        plan_item(OP_RUN, 0);
        // unsorted lists
        plan_item(OP_LEFT, 9);
        plan_item(OP_LEFT, 2);
        plan_item(OP_RIGHT, 2);
        plan_item(OP_RIGHT, 9);
        plan_item(OP_RUN, 0);

        // sender waits for the directed results before the random part
        drain_next = 1'b1;
        while (items_planned < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (!full_done && items_planned > 60) begin
                // both lists past full, two loads dropped on each side
                full_done = 1'b1;
                plan_set(LIST_DEPTH_DF + 2, LIST_DEPTH_DF + 2, int'($urandom_range(0, 400)) - 200,
                         2, 1'b1);
            end else if (r < 8) begin
                plan_set($urandom_range(1, 8), $urandom_range(1, 8), int'($urandom),
                         $urandom_range(1, 1 << 27), 1'b1);
            end else if (r < 20) begin
                plan_set($urandom_range(0, 8), $urandom_range(0, 8),
                         int'($urandom_range(0, 40)) - 20, 0, 1'b0);
            end else begin
                start = ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                    : int'($urandom_range(0, 200)) - 100;
                plan_set($urandom_range(0, 10), $urandom_range(0, 10), start,
                         $urandom_range(1, 3), 1'b1);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_todo.size() != 0 || drv_valid || owed_matches.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (owed_matches.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, owed_matches.size());
        end

        $display("sent %0d items in %0d runs, %0d loads dropped on full lists",
                 items_sent, runs_sent, loads_dropped);
        $display("checked %0d results, %0d mismatches", results_seen, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
